@@ rtl/core/multi_slot_software_timer_macros.svh @@
// ----------------------------------------------------------------------------
// Timer table assertion macros
// Shared concurrent assertion forms used by the timer table RTL.
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_SOFTWARE_TIMER_MACROS_SVH
`define MULTI_SLOT_SOFTWARE_TIMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer table assertion failed");

// Next-cycle implication, checked outside reset.
`define MST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer table assertion failed");

`endif

@@ rtl/core/mst_pkg.sv @@
// ----------------------------------------------------------------------------
// Timer table package
// Field widths, request and result codes, and reset constants.
// ----------------------------------------------------------------------------
package mst_pkg;

  // Port field widths.
  localparam int ACTION_W = 3;
  localparam int ID_W     = 4;
  localparam int MS_W     = 24;
  localparam int KIND_W   = 3;
  localparam int TICK_W   = 10;

  // Tick length after reset, in milliseconds.
  localparam logic [TICK_W-1:0] TICK_MS_RESET = 10'd100;

  // Request actions.
  localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_RESET  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd4;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACK       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXPIRY    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd5;

endpackage

@@ rtl/core/mst_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mst_ram #(
  parameter int WIDTH = 51,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/multi_slot_software_timer.sv @@
// ----------------------------------------------------------------------------
// Multi-slot software timer table
// Tick-driven table of one-shot and periodic timers with add, remove,
// count reset, query and tick requests.
// ----------------------------------------------------------------------------
// The block handles one request at a time and holds in_stall high while it
// works. An add scans the valid bits one slot per cycle. Remove, reset and
// query on a live slot read the RAM word, then update it or take the answer
// from it, then give the result; on a free slot they go straight to the
// result. A tick walks all slots: a free slot is skipped, and a live slot
// goes through a RAM read, the shared multiply of the count by tick_ms, and
// the compare and write back, with the closing result after the walk. The
// single RAM read port and the one shared multiplier make a live slot take
// these steps one after another. Results leave through an output register,
// so a new request may be taken while the last result still waits. Per-slot
// state beyond the valid bits lives in RAM and needs no clearing pass after
// reset.
`include "multi_slot_software_timer_macros.svh"

module multi_slot_software_timer #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mst_pkg::ACTION_W-1:0]  in_action,
  input  logic [mst_pkg::ID_W-1:0]      in_timer_id,
  input  logic [mst_pkg::MS_W-1:0]      in_first_ms,
  input  logic [mst_pkg::MS_W-1:0]      in_period_ms,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mst_pkg::KIND_W-1:0]    out_kind,
  output logic [mst_pkg::ID_W-1:0]      out_slot_id,
  output logic                          out_exists,
  output logic                          out_last,
  // Tick length register.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mst_pkg::TICK_W-1:0]    cfg_tick_ms
);

  import mst_pkg::*;

  localparam int IDX_W    = $clog2(SLOTS);
  localparam int PROD_W   = TIME_BITS + TICK_W;
  localparam int INT_LSB  = 0;
  localparam int TCK_LSB  = TIME_BITS;
  localparam int PEND_BIT = 2 * TIME_BITS;
  localparam int REM_BIT  = 2 * TIME_BITS + 1;
  localparam int PER_BIT  = 2 * TIME_BITS + 2;
  localparam int WORD_W   = 2 * TIME_BITS + 3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_ADD_EXP,
    S_MRD,
    S_MOD,
    S_TCHK,
    S_TMUL,
    S_TUPD,
    S_LAST
  } state_t;

  // Registers.
  state_t                 state_r, state_nxt;
  logic [TICK_W-1:0]      tick_ms_r, tick_ms_nxt;
  logic [SLOTS-1:0]       valid_r, valid_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [ACTION_W-1:0]    action_r, action_nxt;
  logic [ID_W-1:0]        id_r, id_nxt;
  logic                   in_range_r, in_range_nxt;
  logic                   first_zero_r, first_zero_nxt;
  logic                   periodic_r, periodic_nxt;
  logic [TIME_BITS-1:0]   interval_r, interval_nxt;
  logic [WORD_W-1:0]      ent_r, ent_nxt;
  logic [TIME_BITS-1:0]   cnt_r, cnt_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic [KIND_W-1:0]      pend_kind_r, pend_kind_nxt;
  logic [ID_W-1:0]        pend_slot_r, pend_slot_nxt;
  logic                   pend_exists_r, pend_exists_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]      out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]        out_slot_r, out_slot_nxt;
  logic                   out_exists_r, out_exists_nxt;
  logic                   out_last_r, out_last_nxt;

  // Combinational helpers.
  logic                   can_push;
  logic                   push;
  logic [KIND_W-1:0]      push_kind;
  logic [ID_W-1:0]        push_slot;
  logic                   push_exists;
  logic                   push_last;
  logic                   in_accept;
  logic                   in_range;
  logic [IDX_W-1:0]       in_idx;
  logic [IDX_W-1:0]       id_idx;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [WORD_W-1:0]      ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [WORD_W-1:0]      ram_rdata;
  logic [TIME_BITS-1:0]   rd_ticks;
  logic [TIME_BITS-1:0]   cnt_inc;
  logic                   expired;
  logic                   need_emit;
  logic                   last_idx;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign in_range  = (32'(in_timer_id) < 32'(SLOTS));
  assign in_idx    = IDX_W'(in_timer_id);
  assign id_idx    = IDX_W'(id_r);
  assign can_push  = !out_valid_r || !out_stall;
  assign last_idx  = (idx_r == IDX_W'(SLOTS - 1));

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_slot_id = out_slot_r;
  assign out_exists  = out_exists_r;
  assign out_last    = out_last_r;

  // Per-slot timer words: flags, tick count and interval.
  mst_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Count after this tick, saturating, and the expiry compare.
  assign rd_ticks  = ram_rdata[TCK_LSB +: TIME_BITS];
  assign cnt_inc   = (rd_ticks == {TIME_BITS{1'b1}}) ? rd_ticks : rd_ticks + 1'b1;
  assign expired   = (prod_r >= PROD_W'(ent_r[INT_LSB +: TIME_BITS]));
  assign need_emit = expired && !ent_r[REM_BIT];

  // Sequencer, RAM control and result staging.
  always_comb begin
    state_nxt       = state_r;
    tick_ms_nxt     = tick_ms_r;
    valid_nxt       = valid_r;
    idx_nxt         = idx_r;
    action_nxt      = action_r;
    id_nxt          = id_r;
    in_range_nxt    = in_range_r;
    first_zero_nxt  = first_zero_r;
    periodic_nxt    = periodic_r;
    interval_nxt    = interval_r;
    ent_nxt         = ent_r;
    cnt_nxt         = cnt_r;
    prod_nxt        = prod_r;
    pend_kind_nxt   = pend_kind_r;
    pend_slot_nxt   = pend_slot_r;
    pend_exists_nxt = pend_exists_r;
    push            = 1'b0;
    push_kind       = KIND_ADDED;
    push_slot       = '0;
    push_exists     = 1'b0;
    push_last       = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = idx_r;
    ram_wdata       = ent_r;
    ram_raddr       = (state_r == S_MRD) ? id_idx : idx_r;

    if (cfg_valid && cfg_ready) begin
      tick_ms_nxt = cfg_tick_ms;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          action_nxt     = in_action;
          id_nxt         = in_timer_id;
          in_range_nxt   = in_range;
          first_zero_nxt = (in_first_ms == '0);
          periodic_nxt   = (in_period_ms != '0);
          interval_nxt   = (in_period_ms != '0) ? TIME_BITS'(in_period_ms)
                                                : TIME_BITS'(in_first_ms);
          idx_nxt        = '0;
          pend_slot_nxt  = '0;
          pend_exists_nxt = 1'b0;
          case (in_action)
            ACT_ADD: begin
              state_nxt = S_SCAN;
            end
            ACT_REMOVE, ACT_RESET: begin
              pend_kind_nxt = KIND_ACK;
              state_nxt     = (in_range && valid_r[in_idx]) ? S_MRD : S_LAST;
            end
            ACT_QUERY: begin
              pend_kind_nxt = KIND_QUERY;
              pend_slot_nxt = in_timer_id;
              state_nxt     = (in_range && valid_r[in_idx]) ? S_MRD : S_LAST;
            end
            ACT_TICK: begin
              state_nxt = S_TCHK;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // Lowest free slot search, one slot a cycle.
      S_SCAN: begin
        if (!valid_r[idx_r]) begin
          valid_nxt[idx_r] = 1'b1;
          ram_we           = 1'b1;
          ram_wdata        = {periodic_r, 1'b0, 1'b0, {TIME_BITS{1'b0}}, interval_r};
          pend_kind_nxt    = KIND_ADDED;
          pend_slot_nxt    = ID_W'(idx_r);
          state_nxt        = first_zero_r ? S_ADD_EXP : S_LAST;
        end else if (last_idx) begin
          pend_kind_nxt = KIND_FULL;
          pend_slot_nxt = '0;
          state_nxt     = S_LAST;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // Immediate expiry of a new timer with a zero first delay.
      S_ADD_EXP: begin
        if (can_push) begin
          push      = 1'b1;
          push_kind = KIND_EXPIRY;
          push_slot = ID_W'(idx_r);
          state_nxt = S_LAST;
        end
      end

      // Read of the addressed slot.
      S_MRD: begin
        state_nxt = S_MOD;
      end

      // Flag update or query answer from the slot word.
      S_MOD: begin
        ram_waddr = id_idx;
        ram_wdata = ram_rdata;
        case (action_r)
          ACT_REMOVE: begin
            ram_we             = 1'b1;
            ram_wdata[PER_BIT] = 1'b0;
            ram_wdata[REM_BIT] = 1'b1;
          end
          ACT_RESET: begin
            ram_we              = 1'b1;
            ram_wdata[PEND_BIT] = 1'b1;
          end
          default: begin
            pend_exists_nxt = !ram_rdata[REM_BIT];
          end
        endcase
        state_nxt = S_LAST;
      end

      // Tick walk: skip free slots, read live ones.
      S_TCHK: begin
        if (valid_r[idx_r]) begin
          state_nxt = S_TMUL;
        end else if (last_idx) begin
          pend_kind_nxt = KIND_TICK_DONE;
          pend_slot_nxt = '0;
          state_nxt     = S_LAST;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // Shared multiplier: elapsed time of the slot.
      S_TMUL: begin
        ent_nxt   = ram_rdata;
        cnt_nxt   = cnt_inc;
        prod_nxt  = PROD_W'(cnt_inc) * PROD_W'(tick_ms_r);
        state_nxt = S_TUPD;
      end

      // Expiry decision and write back.
      S_TUPD: begin
        if (!need_emit || can_push) begin
          if (need_emit) begin
            push      = 1'b1;
            push_kind = KIND_EXPIRY;
            push_slot = ID_W'(idx_r);
          end
          if (expired && !ent_r[PER_BIT]) begin
            valid_nxt[idx_r] = 1'b0;
          end else begin
            ram_we                           = 1'b1;
            ram_wdata                        = ent_r;
            ram_wdata[PEND_BIT]              = 1'b0;
            ram_wdata[TCK_LSB +: TIME_BITS]  = (ent_r[PEND_BIT] || expired)
                                               ? '0 : cnt_r;
          end
          if (last_idx) begin
            pend_kind_nxt = KIND_TICK_DONE;
            pend_slot_nxt = '0;
            state_nxt     = S_LAST;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_TCHK;
          end
        end
      end

      // Closing result of the request.
      S_LAST: begin
        if (can_push) begin
          push        = 1'b1;
          push_kind   = pend_kind_r;
          push_slot   = pend_slot_r;
          push_exists = pend_exists_r;
          push_last   = 1'b1;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Output register.
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_slot_nxt   = out_slot_r;
    out_exists_nxt = out_exists_r;
    out_last_nxt   = out_last_r;
    if (push) begin
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = push_kind;
      out_slot_nxt   = push_slot;
      out_exists_nxt = push_exists;
      out_last_nxt   = push_last;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_ms_r   <= TICK_MS_RESET;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_ms_r   <= tick_ms_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r         <= idx_nxt;
    action_r      <= action_nxt;
    id_r          <= id_nxt;
    in_range_r    <= in_range_nxt;
    first_zero_r  <= first_zero_nxt;
    periodic_r    <= periodic_nxt;
    interval_r    <= interval_nxt;
    ent_r         <= ent_nxt;
    cnt_r         <= cnt_nxt;
    prod_r        <= prod_nxt;
    pend_kind_r   <= pend_kind_nxt;
    pend_slot_r   <= pend_slot_nxt;
    pend_exists_r <= pend_exists_nxt;
    out_kind_r    <= out_kind_nxt;
    out_slot_r    <= out_slot_nxt;
    out_exists_r  <= out_exists_nxt;
    out_last_r    <= out_last_nxt;
  end

  // Remove, reset and query only reach the RAM for an in-range slot.
  logic mod_ok;
  assign mod_ok = (state_r != S_MOD) || in_range_r;

  // Checks.
  `MST_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_accept && (in_action <= ACT_TICK), in_stall)
  `MST_ASSERT_IMP(a_idle_quiet, clk, rst_n, state_r == S_IDLE, !push && !ram_we)
  `MST_ASSERT_IMP(a_upd_live, clk, rst_n, state_r == S_TUPD, valid_r[idx_r])
  `MST_ASSERT_IMP(a_push_room, clk, rst_n, push, can_push)
  `MST_ASSERT_IMP(a_mod_in_range, clk, rst_n, state_r == S_MOD, mod_ok)

endmodule

@@ test/tb_multi_slot_software_timer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table testbench
// Drives add, remove, count reset, query and tick requests into the timer
// table and checks every result against a slot-by-slot prediction. A short
// directed part covers immediate firing, silent removal, pending resets and
// a full table under a long result hold-off. Random phases then run at
// several tick lengths with the request and result sides idling at random.
// ----------------------------------------------------------------------------
module tb_multi_slot_software_timer;
  import mst_pkg::*;

  localparam int SLOTS        = 16;
  localparam int CLK_HALF_NS  = 10;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASE_ITEMS  = 96;
  localparam int PROD_W       = MS_W + TICK_W;
  localparam logic [MS_W-1:0]     MS_MAX        = '1;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   slot_id;
    logic              exists;
    logic              last;
  } timer_event_t;

  // Block ports; the inputs are driven to known values from time zero.
  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [ACTION_W-1:0] in_action   = ACT_QUERY;
  logic [ID_W-1:0]     in_timer_id = '0;
  logic [MS_W-1:0]     in_first_ms = '0;
  logic [MS_W-1:0]     in_period_ms = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [KIND_W-1:0]   out_kind;
  logic [ID_W-1:0]     out_slot_id;
  logic                out_exists;
  logic                out_last;
  logic                cfg_valid   = 1'b0;
  logic                cfg_ready;
  logic [TICK_W-1:0]   cfg_tick_ms = TICK_MS_RESET;

  // Predicted slot table and tick length.
  bit               slot_live          [SLOTS];
  bit               slot_periodic      [SLOTS];
  bit               slot_removed       [SLOTS];
  bit               slot_reset_pending [SLOTS];
  logic [MS_W-1:0]  slot_count         [SLOTS];
  logic [MS_W-1:0]  slot_interval      [SLOTS];
  logic [TICK_W-1:0] tick_len_ms = TICK_MS_RESET;

  timer_event_t awaited_events[$];
  timer_event_t oldest_event;

  int failures           = 0;
  int requests_sent      = 0;
  int events_checked     = 0;
  int full_refusals      = 0;
  int cycle_count        = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_left          = 0;

  multi_slot_software_timer i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_timer_id  (in_timer_id),
    .in_first_ms  (in_first_ms),
    .in_period_ms (in_period_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_slot_id  (out_slot_id),
    .out_exists   (out_exists),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_tick_ms  (cfg_tick_ms)
  );

  always #CLK_HALF_NS clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d events outstanding.",
               cycle_count, awaited_events.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void await_event(input logic [KIND_W-1:0] kind,
                                      input logic [ID_W-1:0] slot_id,
                                      input logic exists, input logic last);
    timer_event_t ev;
    ev.kind    = kind;
    ev.slot_id = slot_id;
    ev.exists  = exists;
    ev.last    = last;
    awaited_events.push_back(ev);
  endfunction

  // Updates the predicted table for one accepted request and queues the
  // events it causes, in the order the block must return them.
  function automatic void apply_timer_request(input logic [ACTION_W-1:0] action,
                                              input logic [ID_W-1:0] id,
                                              input logic [MS_W-1:0] first_ms,
                                              input logic [MS_W-1:0] period_ms);
    int               free_slot;
    logic [MS_W-1:0]  cnt;
    logic [PROD_W-1:0] product;
    bit               fired;
    free_slot = -1;
    case (action)
      ACT_ADD: begin
        for (int s = SLOTS - 1; s >= 0; s--)
          if (!slot_live[s]) free_slot = s;
        if (free_slot < 0) begin
          full_refusals++;
          await_event(KIND_FULL, '0, 1'b0, 1'b1);
        end else begin
          slot_live[free_slot]          = 1'b1;
          slot_periodic[free_slot]      = (period_ms != '0);
          slot_removed[free_slot]       = 1'b0;
          slot_reset_pending[free_slot] = 1'b0;
          slot_count[free_slot]         = '0;
          slot_interval[free_slot]      = (period_ms != '0) ? period_ms : first_ms;
          if (first_ms == '0)
            await_event(KIND_EXPIRY, free_slot[ID_W-1:0], 1'b0, 1'b0);
          await_event(KIND_ADDED, free_slot[ID_W-1:0], 1'b0, 1'b1);
        end
      end
      ACT_REMOVE: begin
        if (slot_live[id]) begin
          slot_periodic[id] = 1'b0;
          slot_removed[id]  = 1'b1;
        end
        await_event(KIND_ACK, '0, 1'b0, 1'b1);
      end
      ACT_RESET: begin
        if (slot_live[id])
          slot_reset_pending[id] = 1'b1;
        await_event(KIND_ACK, '0, 1'b0, 1'b1);
      end
      ACT_QUERY: begin
        await_event(KIND_QUERY, id, slot_live[id] && !slot_removed[id], 1'b1);
      end
      ACT_TICK: begin
        // Walk the slots in ascending order; the count saturates.
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_live[s]) begin
            cnt = slot_count[s];
            if (cnt != MS_MAX)
              cnt = cnt + 1'b1;
            product = PROD_W'(cnt) * PROD_W'(tick_len_ms);
            fired = (product >= PROD_W'(slot_interval[s]));
            if (fired && !slot_removed[s])
              await_event(KIND_EXPIRY, s[ID_W-1:0], 1'b0, 1'b0);
            if (fired && !slot_periodic[s]) begin
              slot_live[s] = 1'b0;
            end else begin
              if (fired)
                cnt = '0;
              if (slot_reset_pending[s]) begin
                slot_count[s]         = '0;
                slot_reset_pending[s] = 1'b0;
              end else begin
                slot_count[s] = cnt;
              end
            end
          end
        end
        await_event(KIND_TICK_DONE, '0, 1'b0, 1'b1);
      end
      default: begin
        // Unused action codes are ignored by the block.
      end
    endcase
  endfunction

  task automatic log_failure(input string what, input timer_event_t want);
    failures++;
    if (failures <= REPORT_LIMIT)
      $display({"%s at event %0d: expected kind %0d slot %0d exists %0b last %0b,",
                " got kind %0d slot %0d exists %0b last %0b"},
               what, events_checked, want.kind, want.slot_id, want.exists, want.last,
               out_kind, out_slot_id, out_exists, out_last);
  endtask

  // Result side: stall pattern changes on the falling edge. A requested
  // hold-off keeps the stall up until hold_left has run down to zero.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Result side: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (awaited_events.size() == 0) begin
        oldest_event = '0;
        log_failure("Unexpected result", oldest_event);
      end else begin
        oldest_event = awaited_events.pop_front();
        if (out_kind !== oldest_event.kind || out_slot_id !== oldest_event.slot_id ||
            out_exists !== oldest_event.exists || out_last !== oldest_event.last)
          log_failure("Mismatch", oldest_event);
      end
      events_checked++;
    end
  end

  // Offers one request, idling first as the current phase asks, and waits
  // until the block takes it.
  task automatic send_request(input logic [ACTION_W-1:0] action,
                              input logic [ID_W-1:0] id,
                              input logic [MS_W-1:0] first_ms,
                              input logic [MS_W-1:0] period_ms);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= action;
    in_timer_id  <= id;
    in_first_ms  <= first_ms;
    in_period_ms <= period_ms;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    apply_timer_request(action, id, first_ms, period_ms);
    if (action <= ACT_TICK)
      requests_sent++;
  endtask

  // Stops offering requests and waits for every predicted result, then for
  // the longest tick walk in case the block is still busy.
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_tick_length(input logic [TICK_W-1:0] value);
    wait_all_results();
    @(negedge clk);
    cfg_valid   <= 1'b1;
    cfg_tick_ms <= value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    tick_len_ms = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Delays are mostly within a few ticks so that timers really expire.
  function automatic logic [MS_W-1:0] pick_delay_ms();
    logic [MS_W-1:0] delay;
    int r;
    r = $urandom_range(99);
    if (r < 15)
      delay = '0;
    else if (r < 93)
      delay = MS_W'($urandom_range(4 * tick_len_ms + 3, 0));
    else
      delay = MS_W'($urandom);
    return delay;
  endfunction

  // Usually addresses a live slot, otherwise any slot.
  function automatic logic [ID_W-1:0] pick_slot();
    logic [ID_W-1:0] id;
    int start;
    bit found;
    id = ID_W'($urandom_range(SLOTS - 1));
    found = 1'b0;
    if ($urandom_range(3) != 0) begin
      start = $urandom_range(SLOTS - 1);
      for (int k = 0; k < SLOTS; k++)
        if (!found && slot_live[(start + k) % SLOTS]) begin
          id = ID_W'((start + k) % SLOTS);
          found = 1'b1;
        end
    end
    return id;
  endfunction

  // Empty table, an add that fires at once, periodic extremes, and a tick
  // that frees a zero-interval one-shot timer.
  task automatic test_add_and_fire();
    send_request(ACT_QUERY, 4'd15, '0, '0);
    send_request(ACT_TICK, '0, '0, '0);
    send_request(ACT_ADD, '0, '0, '0);
    send_request(ACT_ADD, 4'd15, MS_MAX, MS_MAX);
    send_request(ACT_QUERY, '0, '0, '0);
    send_request(ACT_TICK, '0, '0, '0);
    send_request(ACT_QUERY, '0, '0, '0);
  endtask

  // Pending count reset, remove and reset on a free slot, and a removed
  // timer that expires without a result.
  task automatic test_remove_and_reset();
    send_request(ACT_ADD, '0, 24'd5, 24'd200);
    send_request(ACT_RESET, '0, '0, '0);
    send_request(ACT_TICK, '0, '0, '0);
    send_request(ACT_REMOVE, '0, '0, '0);
    send_request(ACT_QUERY, '0, '0, '0);
    send_request(ACT_REMOVE, 4'd9, '0, '0);
    send_request(ACT_RESET, 4'd9, '0, '0);
    send_request(ACT_TICK, '0, '0, '0);
    send_request(ACT_TICK, '0, '0, '0);
  endtask

  task automatic test_unknown_actions();
    for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
      send_request(a[ACTION_W-1:0], ID_W'($urandom_range(SLOTS - 1)),
                   MS_W'($urandom), MS_W'($urandom));
    send_request(ACT_QUERY, 4'd1, '0, '0);
  endtask

  // The result side holds off while adds keep coming, so the block backs
  // up; the table fills and one more add is refused.
  task automatic test_full_table_backpressure();
    int free_slots;
    logic [MS_W-1:0] first_ms;
    free_slots = 0;
    for (int s = 0; s < SLOTS; s++)
      if (!slot_live[s]) free_slots++;
    sender_idle_pct = 0;
    hold_left = 400;
    for (int k = 0; k <= free_slots; k++) begin
      first_ms = (k == 1) ? '0 : MS_W'(tick_len_ms);
      send_request(ACT_ADD, ID_W'($urandom_range(SLOTS - 1)), first_ms, '0);
    end
    send_request(ACT_TICK, '0, '0, '0);
    wait_all_results();
  endtask

  // Mostly well-formed requests against live slots, with random noise in
  // the unused fields and an occasional unused action code.
  task automatic run_random_phase(input logic [TICK_W-1:0] tick_len, input int idle_pct,
                                  input int stall_pct);
    int done;
    int r;
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     id;
    logic [MS_W-1:0]     first_ms;
    logic [MS_W-1:0]     period_ms;
    set_tick_length(tick_len);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    done = 0;
    while (done < PHASE_ITEMS) begin
      r         = $urandom_range(99);
      id        = ID_W'($urandom_range(SLOTS - 1));
      first_ms  = MS_W'($urandom);
      period_ms = MS_W'($urandom);
      if (r < 5) begin
        action = ACTION_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
      end else if (r < 30) begin
        action    = ACT_ADD;
        first_ms  = pick_delay_ms();
        period_ms = ($urandom_range(1) != 0) ? pick_delay_ms() : '0;
      end else if (r < 40) begin
        action = ACT_REMOVE;
        id     = pick_slot();
      end else if (r < 50) begin
        action = ACT_RESET;
        id     = pick_slot();
      end else if (r < 62) begin
        action = ACT_QUERY;
        id     = pick_slot();
      end else begin
        action = ACT_TICK;
      end
      send_request(action, id, first_ms, period_ms);
      if (action <= ACT_TICK) begin
        done++;
        // Let everything drain now and then.
        if (done % 40 == 0)
          wait_all_results();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_add_and_fire();
    test_remove_and_reset();
    test_unknown_actions();
    test_full_table_backpressure();
    run_random_phase(10'd1, 0, 0);
    run_random_phase(10'd1000, 50, 0);
    run_random_phase(10'd0, 0, 50);
    run_random_phase(10'd1023, 23, 23);
    wait_all_results();

    if (awaited_events.size() != 0) begin
      failures++;
      $display("%0d predicted results never arrived.", awaited_events.size());
    end
    $display("Checked %0d results from %0d requests, %0d of them refused adds.",
             events_checked, requests_sent, full_refusals);
    $display("Tick lengths 100, 1, 1000, 0 and 1023 ms ran under four idle and stall mixes.");
    if (failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
